/* rtl/core/hetm_pkg.sv */
package hetm_pkg;

    // Default face capacity and fixed face size of the mesh table.
    localparam int MAX_FACES_DEF  = 64;
    localparam int EDGES_PER_FACE = 3;

    // All links are 8-bit indices; all ones means no link.
    localparam logic [7:0] NONE = 8'hFF;

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_PUSH      = 3'd1,
        OP_FIND_FACE = 3'd2,
        OP_FIND_EDGE = 3'd3,
        OP_REMOVE    = 3'd4,
        OP_COMPACT   = 3'd5,
        OP_VERIFY    = 3'd6
    } t_opcode;

    // One half-edge record as held in the edge memory.
    typedef struct packed {
        logic [7:0] vertex;
        logic [7:0] face;
        logic [7:0] next;
        logic [7:0] previous;
        logic [7:0] opposite;
    } t_edge;

    localparam int EDGE_W = $bits(t_edge);

    // Redirects one link that points at a given index.
    function automatic logic [7:0] relink8(input logic [7:0] v, input logic [7:0] from,
                                           input logic [7:0] to);
        return (v == from) ? to : v;
    endfunction

endpackage

/* rtl/core/half_edge_triangle_mesh_table_unit.sv */
// Half-edge triangle mesh table.
// A request carries an opcode (clear, push face, find face, find edge,
// remove face, compact, verify), three vertex ids and a face slot. Each
// request produces exactly one response with a success flag, the face or
// half-edge index found or created (255 when none) and the live face and
// half-edge counts after the operation.
// Requests use a valid/ready handshake and are taken one at a time: ready
// is high only while the sequencer is idle. Both memories have a single
// registered read port, so the time an operation takes grows with its
// memory reads: with the live half-edges probed by an edge search, with
// the half-edges swept by a remove, with the edge searches of a push,
// and for a compact with the half-edge and face sweeps made for each
// filled hole and each dropped half-edge.
// A finished response waits in an output register; if the receiver stalls
// the sequencer returns to idle and takes the next request, and only holds
// the following result until the response register has been emptied.
// Reset clears both counts, so the memories start logically empty without
// a clearing pass; the capacity register returns to 64.
module half_edge_triangle_mesh_table_unit #(
    parameter int MAX_FACES = hetm_pkg::MAX_FACES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_vertex_a,
    input  logic [7:0] i_vertex_b,
    input  logic [7:0] i_vertex_c,
    input  logic [5:0] i_face_slot,
    output logic       o_rsp_valid,
    input  logic       i_rsp_ready,
    output logic       o_success,
    output logic [7:0] o_found_index,
    output logic [6:0] o_face_total,
    output logic [7:0] o_edge_total
);

    import hetm_pkg::*;

    localparam int EDGE_SLOTS = MAX_FACES * EDGES_PER_FACE;
    localparam int FAW        = $clog2(MAX_FACES);
    localparam int EAW        = $clog2(EDGE_SLOTS);
    localparam logic [6:0] MAXF      = 7'(MAX_FACES);
    localparam logic [7:0] EDGE_MAX8 = 8'(EDGE_SLOTS);

    typedef enum logic [5:0] {
        S_IDLE, S_DISP, S_FIN,
        S_FD_RD, S_FD_CHK, S_FD_NX,
        S_P_FOUND, S_P_OWN, S_P_STEP, S_P_CAP, S_P_WR,
        S_P_OPP, S_P_OW1, S_P_OR, S_P_OW2, S_P_ONX,
        S_FF_RD, S_FF_E0, S_FF_E1, S_FF_E2, S_FF_E3,
        S_FE_DONE, S_RM_CHK, S_RM_END,
        S_SW_RD, S_SW_WR, S_FS_RD, S_FS_WR,
        S_CA_NEXT, S_CA_CHK, S_CA_MV1, S_CA_MV2, S_CA_MV3,
        S_CB_NEXT, S_CB_CHK, S_CB_OPP,
        S_DR_CP, S_DR_CW, S_DR_FS, S_DR_END,
        S_V_NEXT, S_V_ST, S_V_CUR, S_V_OPP, S_V_PRV0, S_V_PRV, S_V_NXT
    } t_state;

    function automatic logic [7:0] pick3(input logic [1:0] s, input logic [7:0] a,
                                         input logic [7:0] b, input logic [7:0] c);
        logic [7:0] v;
        case (s)
            2'd0:    v = a;
            2'd1:    v = b;
            default: v = c;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] inc3(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    // Sequencer state and registered outputs.
    t_state     r_state, n_state;
    t_opcode    r_op, n_op;
    logic [7:0] r_va, n_va, r_vb, n_vb, r_vc, n_vc;
    logic [5:0] r_slot, n_slot;
    logic [6:0] r_cap, n_cap;
    logic [6:0] r_fc, n_fc;
    logic [7:0] r_ec, n_ec;
    logic       r_ok, n_ok;
    logic [7:0] r_found, n_found;
    logic       r_o_valid, n_o_valid;
    logic       r_o_success, n_o_success;
    logic [7:0] r_o_found, n_o_found;
    logic [6:0] r_o_fc, n_o_fc;
    logic [7:0] r_o_ec, n_o_ec;
    // Edge search.
    logic [7:0] r_i, n_i, r_fa, n_fa, r_fb, n_fb, r_lim, n_lim, r_fres, n_fres;
    t_state     r_fd_ret, n_fd_ret;
    // Face push.
    logic [1:0] r_k, n_k, r_added, n_added;
    logic [7:0] r_e0, n_e0, r_e1, n_e1, r_e2, n_e2;
    // Link sweeps.
    logic [7:0] r_j, n_j, r_sw_from, n_sw_from, r_sw_to, n_sw_to, r_sw_lim, n_sw_lim;
    logic       r_sw_link, n_sw_link;
    t_state     r_sw_ret, n_sw_ret;
    // Compaction, face search and verification.
    logic [6:0] r_f, n_f;
    logic [7:0] r_last, n_last, r_di, n_di, r_x, n_x, r_y, n_y;
    logic [7:0] r_start, n_start, r_idx, n_idx;
    logic [8:0] r_cyc, n_cyc;
    t_edge      r_cur, n_cur;

    // Memory ports.
    logic       e_we, f_we;
    logic [7:0] e_waddr, e_raddr, f_waddr, f_raddr, f_wdata, f_rdata;
    t_edge      e_wdata, rd, wtmp;
    logic [EDGE_W-1:0] e_rdata;

    logic [6:0] cap_eff;
    logic [8:0] cap3, ec_add;
    logic [7:0] vk, ek, ek1, ek2;
    logic [1:0] kn;

    hetm_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_SLOTS)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr[EAW-1:0]),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr[EAW-1:0]),
        .o_rdata (e_rdata)
    );

    hetm_ram #(.WIDTH(8), .DEPTH(MAX_FACES)) u_face_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr[FAW-1:0]),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr[FAW-1:0]),
        .o_rdata (f_rdata)
    );

    assign rd      = t_edge'(e_rdata);
    assign cap_eff = (r_cap < MAXF) ? r_cap : MAXF;
    assign cap3    = {1'b0, cap_eff, 1'b0} + {2'b00, cap_eff};
    assign ec_add  = {1'b0, r_ec} + {7'b0, r_added};
    assign vk      = pick3(r_k, r_va, r_vb, r_vc);
    assign ek      = pick3(r_k, r_e0, r_e1, r_e2);
    assign ek1     = pick3(inc3(r_k), r_e0, r_e1, r_e2);
    assign ek2     = pick3(inc3(inc3(r_k)), r_e0, r_e1, r_e2);
    assign kn      = r_k + 2'd1;

    always_comb begin
        n_state = r_state;   n_op = r_op;     n_va = r_va;     n_vb = r_vb;
        n_vc = r_vc;         n_slot = r_slot; n_fc = r_fc;     n_ec = r_ec;
        n_ok = r_ok;         n_found = r_found;
        n_o_success = r_o_success; n_o_found = r_o_found;
        n_o_fc = r_o_fc;     n_o_ec = r_o_ec;
        n_i = r_i;   n_fa = r_fa;  n_fb = r_fb;  n_lim = r_lim;  n_fres = r_fres;
        n_fd_ret = r_fd_ret;
        n_k = r_k;   n_added = r_added; n_e0 = r_e0; n_e1 = r_e1; n_e2 = r_e2;
        n_j = r_j;   n_sw_from = r_sw_from; n_sw_to = r_sw_to; n_sw_lim = r_sw_lim;
        n_sw_link = r_sw_link; n_sw_ret = r_sw_ret;
        n_f = r_f;   n_last = r_last; n_di = r_di; n_x = r_x; n_y = r_y;
        n_start = r_start; n_idx = r_idx; n_cyc = r_cyc; n_cur = r_cur;
        n_cap   = i_cfg_wr_en ? i_cfg_wr_data : r_cap;
        n_o_valid = r_o_valid & ~i_rsp_ready;
        e_we = 1'b0; e_waddr = '0; e_wdata = rd; e_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = NONE; f_raddr = '0;
        wtmp = rd;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op    = t_opcode'(i_opcode);
                    n_va    = i_vertex_a;
                    n_vb    = i_vertex_b;
                    n_vc    = i_vertex_c;
                    n_slot  = i_face_slot;
                    n_ok    = 1'b0;
                    n_found = NONE;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_FIN;
                case (r_op)
                    OP_CLEAR: begin
                        n_fc = '0;
                        n_ec = '0;
                        n_ok = 1'b1;
                    end
                    OP_PUSH: begin
                        if (r_fc < cap_eff) begin
                            n_k = '0; n_added = '0;
                            n_fa = r_va; n_fb = r_vb; n_lim = r_ec; n_i = '0;
                            n_fd_ret = S_P_FOUND;
                            n_state  = S_FD_RD;
                        end
                    end
                    OP_FIND_FACE: begin
                        n_f = '0;
                        n_state = S_FF_RD;
                    end
                    OP_FIND_EDGE: begin
                        n_fa = r_va; n_fb = r_vb; n_lim = r_ec; n_i = '0;
                        n_fd_ret = S_FE_DONE;
                        n_state  = S_FD_RD;
                    end
                    OP_REMOVE: begin
                        if ({1'b0, r_slot} < r_fc) begin
                            f_raddr = {2'b00, r_slot};
                            n_state = S_RM_CHK;
                        end
                    end
                    OP_COMPACT: begin
                        n_f = r_fc;
                        n_state = S_CA_NEXT;
                    end
                    OP_VERIFY: begin
                        n_f = '0;
                        n_state = S_V_NEXT;
                    end
                    default: ;
                endcase
            end
            S_FIN: begin
                if (!r_o_valid || i_rsp_ready) begin
                    n_o_valid   = 1'b1;
                    n_o_success = r_ok;
                    n_o_found   = r_found;
                    n_o_fc      = r_fc;
                    n_o_ec      = r_ec;
                    n_state     = S_IDLE;
                end
            end

            // Edge search: first live half-edge from r_fa whose next starts at r_fb.
            S_FD_RD: begin
                if (r_i >= r_lim) begin
                    n_fres  = NONE;
                    n_state = r_fd_ret;
                end else begin
                    e_raddr = r_i;
                    n_state = S_FD_CHK;
                end
            end
            S_FD_CHK: begin
                if (rd.vertex == r_fa && rd.next < r_lim) begin
                    e_raddr = rd.next;
                    n_state = S_FD_NX;
                end else begin
                    n_i = r_i + 8'd1;
                    n_state = S_FD_RD;
                end
            end
            S_FD_NX: begin
                if (rd.vertex == r_fb) begin
                    n_fres  = r_i;
                    n_state = r_fd_ret;
                end else begin
                    n_i = r_i + 8'd1;
                    n_state = S_FD_RD;
                end
            end

            // Face push.
            S_P_FOUND: begin
                if (r_fres == NONE) begin
                    case (r_k)
                        2'd0:    n_e0 = ec_add[7:0];
                        2'd1:    n_e1 = ec_add[7:0];
                        default: n_e2 = ec_add[7:0];
                    endcase
                    n_added = r_added + 2'd1;
                    n_state = S_P_STEP;
                end else begin
                    case (r_k)
                        2'd0:    n_e0 = r_fres;
                        2'd1:    n_e1 = r_fres;
                        default: n_e2 = r_fres;
                    endcase
                    e_raddr = r_fres;
                    n_state = S_P_OWN;
                end
            end
            S_P_OWN: begin
                n_state = (rd.face != NONE) ? S_FIN : S_P_STEP;
            end
            S_P_STEP: begin
                if (r_k == 2'd2) begin
                    n_state = S_P_CAP;
                end else begin
                    n_k  = kn;
                    n_fa = pick3(kn, r_va, r_vb, r_vc);
                    n_fb = pick3(inc3(kn), r_va, r_vb, r_vc);
                    n_lim = r_ec; n_i = '0;
                    n_fd_ret = S_P_FOUND;
                    n_state  = S_FD_RD;
                end
            end
            S_P_CAP: begin
                if (ec_add > cap3) begin
                    n_state = S_FIN;
                end else begin
                    n_k = '0;
                    n_state = S_P_WR;
                end
            end
            S_P_WR: begin
                e_we    = 1'b1;
                e_waddr = ek;
                e_wdata = '{vertex: vk, face: {1'b0, r_fc}, next: ek1, previous: ek2,
                            opposite: NONE};
                if (r_k == 2'd2) begin
                    n_ec = ec_add[7:0];
                    n_k  = '0;
                    n_fa = r_vb; n_fb = r_va; n_lim = ec_add[7:0]; n_i = '0;
                    n_fd_ret = S_P_OPP;
                    n_state  = S_FD_RD;
                end else begin
                    n_k = kn;
                end
            end
            S_P_OPP: begin
                e_raddr = ek;
                n_state = S_P_OW1;
            end
            S_P_OW1: begin
                wtmp          = rd;
                wtmp.opposite = r_fres;
                e_we = 1'b1; e_waddr = ek; e_wdata = wtmp;
                n_state = (r_fres != NONE) ? S_P_OR : S_P_ONX;
            end
            S_P_OR: begin
                e_raddr = r_fres;
                n_state = S_P_OW2;
            end
            S_P_OW2: begin
                wtmp          = rd;
                wtmp.opposite = ek;
                e_we = 1'b1; e_waddr = r_fres; e_wdata = wtmp;
                n_state = S_P_ONX;
            end
            S_P_ONX: begin
                if (r_k == 2'd2) begin
                    f_we    = 1'b1;
                    f_waddr = {1'b0, r_fc};
                    f_wdata = r_e0;
                    n_found = {1'b0, r_fc};
                    n_fc    = r_fc + 7'd1;
                    n_ok    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_k  = kn;
                    n_fa = pick3(inc3(kn), r_va, r_vb, r_vc);
                    n_fb = pick3(kn, r_va, r_vb, r_vc);
                    n_lim = r_ec; n_i = '0;
                    n_fd_ret = S_P_OPP;
                    n_state  = S_FD_RD;
                end
            end

            // Face search: walk three links from each face's first half-edge.
            S_FF_RD: begin
                if (r_f >= r_fc) begin
                    n_state = S_FIN;
                end else begin
                    f_raddr = {1'b0, r_f};
                    n_state = S_FF_E0;
                end
            end
            S_FF_E0: begin
                if (f_rdata >= r_ec) begin
                    n_f = r_f + 7'd1;
                    n_state = S_FF_RD;
                end else begin
                    n_start = f_rdata;
                    e_raddr = f_rdata;
                    n_state = S_FF_E1;
                end
            end
            S_FF_E1: begin
                n_x = rd.vertex;
                if (rd.next >= r_ec) begin
                    n_f = r_f + 7'd1;
                    n_state = S_FF_RD;
                end else begin
                    e_raddr = rd.next;
                    n_state = S_FF_E2;
                end
            end
            S_FF_E2: begin
                n_y = rd.vertex;
                if (rd.next >= r_ec) begin
                    n_f = r_f + 7'd1;
                    n_state = S_FF_RD;
                end else begin
                    e_raddr = rd.next;
                    n_state = S_FF_E3;
                end
            end
            S_FF_E3: begin
                if (rd.next == r_start &&
                    (r_va == r_x || r_va == r_y || r_va == rd.vertex) &&
                    (r_vb == r_x || r_vb == r_y || r_vb == rd.vertex) &&
                    (r_vc == r_x || r_vc == r_y || r_vc == rd.vertex)) begin
                    n_found = {1'b0, r_f};
                    n_ok    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_f = r_f + 7'd1;
                    n_state = S_FF_RD;
                end
            end

            S_FE_DONE: begin
                n_found = r_fres;
                n_ok    = (r_fres != NONE);
                n_state = S_FIN;
            end

            // Face removal.
            S_RM_CHK: begin
                if (f_rdata == NONE) begin
                    n_state = S_FIN;
                end else begin
                    n_j = '0; n_sw_link = 1'b0; n_sw_from = {2'b00, r_slot};
                    n_sw_to = NONE; n_sw_lim = r_ec; n_sw_ret = S_RM_END;
                    n_state = S_SW_RD;
                end
            end
            S_RM_END: begin
                f_we    = 1'b1;
                f_waddr = {2'b00, r_slot};
                f_wdata = NONE;
                n_found = {2'b00, r_slot};
                n_ok    = 1'b1;
                n_state = S_FIN;
            end

            // Read-modify-write sweep over half-edges: either the face field or
            // the three links are redirected from r_sw_from to r_sw_to.
            S_SW_RD: begin
                if (r_j >= r_sw_lim) begin
                    n_state = r_sw_ret;
                end else begin
                    e_raddr = r_j;
                    n_state = S_SW_WR;
                end
            end
            S_SW_WR: begin
                wtmp = rd;
                if (r_sw_link) begin
                    wtmp.next     = relink8(rd.next, r_sw_from, r_sw_to);
                    wtmp.previous = relink8(rd.previous, r_sw_from, r_sw_to);
                    wtmp.opposite = relink8(rd.opposite, r_sw_from, r_sw_to);
                end else begin
                    wtmp.face     = relink8(rd.face, r_sw_from, r_sw_to);
                end
                e_we = (wtmp != rd); e_waddr = r_j; e_wdata = wtmp;
                n_j = r_j + 8'd1;
                n_state = S_SW_RD;
            end

            // Sweep over face first-edge entries after a half-edge moved.
            S_FS_RD: begin
                if (r_j >= {1'b0, r_fc}) begin
                    n_state = S_DR_END;
                end else begin
                    f_raddr = r_j;
                    n_state = S_FS_WR;
                end
            end
            S_FS_WR: begin
                f_we    = (f_rdata == r_last);
                f_waddr = r_j;
                f_wdata = r_di;
                n_j     = r_j + 8'd1;
                n_state = S_FS_RD;
            end

            // Compaction, first the face holes from the top down.
            S_CA_NEXT: begin
                if (r_f == '0) begin
                    n_di = r_ec;
                    n_state = S_CB_NEXT;
                end else begin
                    f_raddr = {1'b0, r_f - 7'd1};
                    n_f     = r_f - 7'd1;
                    n_state = S_CA_CHK;
                end
            end
            S_CA_CHK: begin
                if (f_rdata == NONE) begin
                    n_last = {1'b0, r_fc - 7'd1};
                    n_j = '0; n_sw_link = 1'b0; n_sw_from = {1'b0, r_fc - 7'd1};
                    n_sw_to = {1'b0, r_f}; n_sw_lim = r_ec; n_sw_ret = S_CA_MV1;
                    n_state = S_SW_RD;
                end else begin
                    n_state = S_CA_NEXT;
                end
            end
            S_CA_MV1: begin
                f_raddr = r_last;
                n_state = S_CA_MV2;
            end
            S_CA_MV2: begin
                f_we = 1'b1; f_waddr = {1'b0, r_f}; f_wdata = f_rdata;
                n_state = S_CA_MV3;
            end
            S_CA_MV3: begin
                f_we = 1'b1; f_waddr = r_last; f_wdata = NONE;
                n_fc = r_last[6:0];
                n_state = S_CA_NEXT;
            end

            // Then the ownerless half-edges whose opposite is absent or also ownerless, from the top down.
            S_CB_NEXT: begin
                if (r_di == '0) begin
                    n_ok = 1'b1;
                    n_state = S_FIN;
                end else begin
                    e_raddr = r_di - 8'd1;
                    n_di    = r_di - 8'd1;
                    n_state = S_CB_CHK;
                end
            end
            S_CB_CHK: begin
                if (rd.face != NONE) begin
                    n_state = S_CB_NEXT;
                end else if (rd.opposite >= r_ec) begin
                    n_last = r_ec - 8'd1;
                    n_j = '0; n_sw_link = 1'b1; n_sw_from = r_di; n_sw_to = NONE;
                    n_sw_lim = r_ec; n_sw_ret = S_DR_CP;
                    n_state = S_SW_RD;
                end else begin
                    e_raddr = rd.opposite;
                    n_state = S_CB_OPP;
                end
            end
            S_CB_OPP: begin
                if (rd.face == NONE) begin
                    n_last = r_ec - 8'd1;
                    n_j = '0; n_sw_link = 1'b1; n_sw_from = r_di; n_sw_to = NONE;
                    n_sw_lim = r_ec; n_sw_ret = S_DR_CP;
                    n_state = S_SW_RD;
                end else begin
                    n_state = S_CB_NEXT;
                end
            end
            S_DR_CP: begin
                if (r_di != r_last) begin
                    e_raddr = r_last;
                    n_state = S_DR_CW;
                end else begin
                    n_state = S_DR_END;
                end
            end
            S_DR_CW: begin
                e_we = 1'b1; e_waddr = r_di; e_wdata = rd;
                n_j = '0; n_sw_link = 1'b1; n_sw_from = r_last; n_sw_to = r_di;
                n_sw_lim = r_last; n_sw_ret = S_DR_FS;
                n_state = S_SW_RD;
            end
            S_DR_FS: begin
                n_j = '0;
                n_state = S_FS_RD;
            end
            S_DR_END: begin
                e_we = 1'b1; e_waddr = r_last; e_wdata = '1;
                n_ec = r_last;
                n_state = S_CB_NEXT;
            end

            // Link verification, one face's half-edge loop at a time.
            S_V_NEXT: begin
                if (r_f >= r_fc) begin
                    n_ok = 1'b1;
                    n_state = S_FIN;
                end else begin
                    f_raddr = {1'b0, r_f};
                    n_state = S_V_ST;
                end
            end
            S_V_ST: begin
                if (f_rdata == NONE) begin
                    n_f = r_f + 7'd1;
                    n_state = S_V_NEXT;
                end else if (f_rdata >= r_ec) begin
                    n_state = S_FIN;
                end else begin
                    n_start = f_rdata; n_idx = f_rdata; n_cyc = '0;
                    e_raddr = f_rdata;
                    n_state = S_V_CUR;
                end
            end
            S_V_CUR: begin
                n_cur = rd;
                if (rd.face != {1'b0, r_f}) begin
                    n_state = S_FIN;
                end else if (rd.opposite != NONE) begin
                    if (rd.opposite >= r_ec) begin
                        n_state = S_FIN;
                    end else begin
                        e_raddr = rd.opposite;
                        n_state = S_V_OPP;
                    end
                end else begin
                    n_state = S_V_PRV0;
                end
            end
            S_V_OPP: begin
                n_state = (rd.opposite != r_idx) ? S_FIN : S_V_PRV0;
            end
            S_V_PRV0: begin
                if (r_cur.previous >= r_ec) begin
                    n_state = S_FIN;
                end else begin
                    e_raddr = r_cur.previous;
                    n_state = S_V_PRV;
                end
            end
            S_V_PRV: begin
                if (rd.next != r_idx || r_cur.next >= r_ec) begin
                    n_state = S_FIN;
                end else begin
                    e_raddr = r_cur.next;
                    n_state = S_V_NXT;
                end
            end
            S_V_NXT: begin
                n_idx = r_cur.next;
                n_cyc = r_cyc + 9'd1;
                if (rd.previous != r_idx || (r_cyc + 9'd1) > {1'b0, r_ec}) begin
                    n_state = S_FIN;
                end else if (r_cur.next == r_start) begin
                    n_f = r_f + 7'd1;
                    n_state = S_V_NEXT;
                end else begin
                    e_raddr = r_cur.next;
                    n_state = S_V_CUR;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cap     <= 7'd64;
            r_fc      <= '0;
            r_ec      <= '0;
            r_o_valid <= 1'b0;
            r_fd_ret  <= S_IDLE;
            r_sw_ret  <= S_IDLE;
        end else begin
            r_state   <= n_state;
            r_cap     <= n_cap;
            r_fc      <= n_fc;
            r_ec      <= n_ec;
            r_o_valid <= n_o_valid;
            r_fd_ret  <= n_fd_ret;
            r_sw_ret  <= n_sw_ret;
        end
        r_op <= n_op;   r_va <= n_va;   r_vb <= n_vb;   r_vc <= n_vc;
        r_slot <= n_slot; r_ok <= n_ok; r_found <= n_found;
        r_o_success <= n_o_success; r_o_found <= n_o_found;
        r_o_fc <= n_o_fc; r_o_ec <= n_o_ec;
        r_i <= n_i; r_fa <= n_fa; r_fb <= n_fb; r_lim <= n_lim; r_fres <= n_fres;
        r_k <= n_k; r_added <= n_added; r_e0 <= n_e0; r_e1 <= n_e1; r_e2 <= n_e2;
        r_j <= n_j; r_sw_from <= n_sw_from; r_sw_to <= n_sw_to; r_sw_lim <= n_sw_lim;
        r_sw_link <= n_sw_link;
        r_f <= n_f; r_last <= n_last; r_di <= n_di; r_x <= n_x; r_y <= n_y;
        r_start <= n_start; r_idx <= n_idx; r_cyc <= n_cyc; r_cur <= n_cur;
    end

    assign o_req_ready   = (r_state == S_IDLE);
    assign o_rsp_valid   = r_o_valid;
    assign o_success     = r_o_success;
    assign o_found_index = r_o_found;
    assign o_face_total  = r_o_fc;
    assign o_edge_total  = r_o_ec;

`ifndef ASSERT_OFF
    a_edge_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ec <= EDGE_MAX8)
        else $error("half-edge count beyond the table size");

    a_face_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= MAXF)
        else $error("face count beyond the table size");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request taken while a previous one is still in progress");

    a_response_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(r_state == S_FIN))
        else $error("response raised outside the finish step");
`endif

endmodule

/* rtl/core/hetm_ram.sv */
module hetm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port and one registered read port; a read in the same
    // cycle as a write to the same address returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
